### src/blc_pkg.sv
// shared types and constants for the bit-plane life cell engine
// used by every module under src; depends on nothing
package blc_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int N_PLANES   = 24;
	localparam int RULE_W     = 18;
	localparam int COUNT_W    = 7;
	localparam int COORD_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int NBR_CNT_W  = 4;
	localparam int RULE_IDX_W = 5;
	localparam int POS_W      = 4;

	localparam logic [CFG_IDX_W-1:0] REG_RULE_WORD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd2;

	localparam logic [RULE_W-1:0]  RULE_RESET  = 18'd6152;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

	localparam logic [RULE_IDX_W-1:0] SURVIVE_OFFSET = 5'd9;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// read order: eight neighbours, then the cell itself
	localparam logic [POS_W-1:0] POS_UL   = 4'd0;
	localparam logic [POS_W-1:0] POS_UP   = 4'd1;
	localparam logic [POS_W-1:0] POS_UR   = 4'd2;
	localparam logic [POS_W-1:0] POS_LF   = 4'd3;
	localparam logic [POS_W-1:0] POS_RT   = 4'd4;
	localparam logic [POS_W-1:0] POS_DL   = 4'd5;
	localparam logic [POS_W-1:0] POS_DN   = 4'd6;
	localparam logic [POS_W-1:0] POS_DR   = 4'd7;
	localparam logic [POS_W-1:0] POS_SELF = 4'd8;

	typedef struct packed {
		logic clear;
		logic add;
		logic self_ld;
	} lane_ctl_t;

endpackage

### src/bitplane_life_cell_engine.sv
// top level of the bit-plane life cell engine: sequencer, frame memory,
// configuration registers, 24 lanes and the output stage
// depends on blc_pkg, blc_mod, blc_lane and blc_out
// Input channel: in_valid / in_stall carry one transaction per item. operation
// selects a pixel write or a cell evaluate; cell_row and cell_col are reduced
// modulo the effective grid size first. in_stall is high while an item is in
// progress, so items are handled one at a time.
// A write passes through the bit-serial coordinate reduction, the memory write
// and a return to idle before the next acceptance.
// An evaluate runs the reduction, then nine reads of the single-port
// frame memory (eight neighbours and the cell, one per cycle), a drain state for
// the last read data, a state that hands the result to the output register and
// a return to idle; out_valid rises when the output register is loaded.
// All 24 planes are counted in parallel lanes during the reads.
// Output channel: out_valid / out_stall. A result waits in the output
// register while the next item is accepted; if it is still stalled when the
// following result is ready, the sequencer waits.
// Configuration: cfg_write with cfg_index and cfg_data, only while idle.
// Reset (arst_n low) restores the rule word and grid size and empties the
// output register; the frame memory is not cleared, write pixels first.
module bitplane_life_cell_engine
	import blc_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RULE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic [COORD_W-1:0]   cell_row,
	input  logic [COORD_W-1:0]   cell_col,
	input  logic [7:0]           red_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           blue_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           red_out,
	output logic [7:0]           green_out,
	output logic [7:0]           blue_out
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [ST_W-1:0] ST_MOD   = 3'd1;
	localparam logic [ST_W-1:0] ST_WR    = 3'd2;
	localparam logic [ST_W-1:0] ST_RD    = 3'd3;
	localparam logic [ST_W-1:0] ST_DRAIN = 3'd4;
	localparam logic [ST_W-1:0] ST_FIN   = 3'd5;

	logic [RULE_W-1:0]  rule_q;
	logic [COUNT_W-1:0] rows_q;
	logic [COUNT_W-1:0] cols_q;
	logic [COUNT_W-1:0] eff_rows;
	logic [COUNT_W-1:0] eff_cols;

	logic [ST_W-1:0]     state_q;
	logic [POS_W-1:0]    pos_q;
	logic                op_q;
	logic [N_PLANES-1:0] pix_q;
	logic                rd_vld_s1;
	logic                rd_self_s1;

	logic               accept;
	logic               row_busy;
	logic               col_busy;
	logic [COORD_W-1:0] row_r;
	logic [COORD_W-1:0] col_r;
	logic [COUNT_W-1:0] row_w;
	logic [COUNT_W-1:0] col_w;
	logic [COUNT_W-1:0] row_up;
	logic [COUNT_W-1:0] row_dn;
	logic [COUNT_W-1:0] col_lf;
	logic [COUNT_W-1:0] col_rt;
	logic [COUNT_W-1:0] sel_row;
	logic [COUNT_W-1:0] sel_col;
	logic [AW-1:0]      mem_addr;
	logic               mem_we;

	logic [N_PLANES-1:0] mem [DEPTH];
	logic [N_PLANES-1:0] rd_data_s1;

	lane_ctl_t           lane_ctl;
	logic [N_PLANES-1:0] lane_bits;
	logic                out_free;
	logic                out_load;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= RULE_RESET;
			rows_q <= COUNT_RESET;
			cols_q <= COUNT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_RULE_WORD: rule_q <= cfg_data;
				REG_ROW_COUNT: rows_q <= cfg_data[COUNT_W-1:0];
				REG_COL_COUNT: cols_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize clamps to the store dimension
	always_comb begin
		if (rows_q == '0) begin
			eff_rows = COUNT_W'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			eff_rows = COUNT_W'(MAX_ROWS);
		end else begin
			eff_rows = rows_q;
		end
		if (cols_q == '0) begin
			eff_cols = COUNT_W'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			eff_cols = COUNT_W'(MAX_COLS);
		end else begin
			eff_cols = cols_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	blc_mod u_row_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (cell_row),
		.divisor   (eff_rows),
		.busy      (row_busy),
		.remainder (row_r)
	);

	blc_mod u_col_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (cell_col),
		.divisor   (eff_cols),
		.busy      (col_busy),
		.remainder (col_r)
	);

	assign row_w = COUNT_W'(row_r);
	assign col_w = COUNT_W'(col_r);

	// toroidal neighbours; coordinates are already below the grid size
	assign row_up = (row_w == '0) ? eff_rows - 1'b1 : row_w - 1'b1;
	assign row_dn = (row_w + 1'b1 == eff_rows) ? '0 : row_w + 1'b1;
	assign col_lf = (col_w == '0) ? eff_cols - 1'b1 : col_w - 1'b1;
	assign col_rt = (col_w + 1'b1 == eff_cols) ? '0 : col_w + 1'b1;

	always_comb begin
		sel_row = row_w;
		sel_col = col_w;
		if (state_q == ST_RD) begin
			case (pos_q)
				POS_UL:   begin sel_row = row_up; sel_col = col_lf; end
				POS_UP:   begin sel_row = row_up; sel_col = col_w;  end
				POS_UR:   begin sel_row = row_up; sel_col = col_rt; end
				POS_LF:   begin sel_row = row_w;  sel_col = col_lf; end
				POS_RT:   begin sel_row = row_w;  sel_col = col_rt; end
				POS_DL:   begin sel_row = row_dn; sel_col = col_lf; end
				POS_DN:   begin sel_row = row_dn; sel_col = col_w;  end
				POS_DR:   begin sel_row = row_dn; sel_col = col_rt; end
				default:  begin sel_row = row_w;  sel_col = col_w;  end
			endcase
		end
	end

	assign mem_addr = AW'(AW'(sel_row) * AW'(MAX_COLS)) + AW'(sel_col);
	assign mem_we   = (state_q == ST_WR);

	// single-port frame memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= pix_q;
		end
		rd_data_s1 <= mem[mem_addr];
	end

	assign out_load = (state_q == ST_FIN) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_self_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= (state_q == ST_RD);
			rd_self_s1 <= (state_q == ST_RD) && (pos_q == POS_SELF);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (!row_busy && !col_busy) begin
						pos_q   <= POS_UL;
						state_q <= (op_q == OP_EVAL) ? ST_RD : ST_WR;
					end
				end
				ST_WR: begin
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == POS_SELF) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			pix_q <= {red_in, green_in, blue_in};
		end
	end

	assign lane_ctl.clear   = accept;
	assign lane_ctl.add     = rd_vld_s1 && !rd_self_s1;
	assign lane_ctl.self_ld = rd_vld_s1 && rd_self_s1;

	for (genvar k = 0; k < N_PLANES; k++) begin : g_lane
		blc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (lane_ctl),
			.bit_in    (rd_data_s1[k]),
			.rule_word (rule_q),
			.next_bit  (lane_bits[k])
		);
	end

	blc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.lane_bits (lane_bits),
		.out_stall (out_stall),
		.free      (out_free),
		.out_valid (out_valid),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

endmodule

### src/blc_mod.sv
// restoring remainder unit: coordinate modulo grid size, one bit per cycle
// depends on blc_pkg
module blc_mod
	import blc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COORD_W-1:0] dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               busy,
	output logic [COORD_W-1:0] remainder
);

	localparam int STEP_W = $clog2(COORD_W + 1);

	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] dvd_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic [COUNT_W-1:0] trial;

	assign trial = {rem_q, dvd_q[COORD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(COORD_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COORD_W-2:0], 1'b0};
			// remainder stays below the divisor, so it fits the coordinate width
			if (trial >= divisor) begin
				rem_q <= COORD_W'(trial - divisor);
			end else begin
				rem_q <= COORD_W'(trial);
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

### src/blc_lane.sv
// one bit-plane lane: neighbour counter, own bit and rule lookup
// depends on blc_pkg
module blc_lane
	import blc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lane_ctl_t         ctl,
	input  logic              bit_in,
	input  logic [RULE_W-1:0] rule_word,
	output logic              next_bit
);

	logic [NBR_CNT_W-1:0]  count_q;
	logic                  self_q;
	logic [RULE_IDX_W-1:0] rule_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			self_q  <= 1'b0;
		end else if (ctl.clear) begin
			count_q <= '0;
			self_q  <= 1'b0;
		end else begin
			if (ctl.add && bit_in) begin
				count_q <= count_q + 1'b1;
			end
			if (ctl.self_ld) begin
				self_q <= bit_in;
			end
		end
	end

	// survival half of the rule word sits above the birth half
	assign rule_idx = RULE_IDX_W'(count_q) + (self_q ? SURVIVE_OFFSET : '0);
	assign next_bit = rule_word[rule_idx];

endmodule

### src/blc_out.sv
// merging stage: gathers the lane results into one colour and holds it
// until the receiver takes the transaction; depends on blc_pkg
module blc_out
	import blc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [N_PLANES-1:0] lane_bits,
	input  logic                out_stall,
	output logic                free,
	output logic                out_valid,
	output logic [7:0]          red_out,
	output logic [7:0]          green_out,
	output logic [7:0]          blue_out
);

	logic                valid_q;
	logic [N_PLANES-1:0] color_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			color_q <= lane_bits;
		end
	end

	assign out_valid = valid_q;
	assign red_out   = color_q[23:16];
	assign green_out = color_q[15:8];
	assign blue_out  = color_q[7:0];

endmodule

### verif/tb_bitplane_life_cell_engine.sv
`timescale 1ns / 1ps
// testbench for bitplane_life_cell_engine: drives pixel writes and cell evaluates, results checked
// against an in-bench predictor of the 24 bit-plane toroidal automata
// depends on blc_pkg and the engine rtl under src
module tb_bitplane_life_cell_engine;
	import blc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT   = 4000;
	localparam int CFG_HOLDOFF  = 24;
	localparam int END_HOLDOFF  = 40;
	localparam int PRINT_LIMIT  = 50;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RULE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 operation = OP_WRITE;
	logic [COORD_W-1:0]   cell_row = '0;
	logic [COORD_W-1:0]   cell_col = '0;
	logic [7:0]           red_in = '0;
	logic [7:0]           green_in = '0;
	logic [7:0]           blue_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           red_out;
	logic [7:0]           green_out;
	logic [7:0]           blue_out;

	bitplane_life_cell_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.cell_row  (cell_row),
		.cell_col  (cell_col),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state: copy of the frame store, written map and registers
	logic [23:0]        pixel_copy [DEF_MAX_ROWS*DEF_MAX_COLS];
	bit                 pixel_written [DEF_MAX_ROWS*DEF_MAX_COLS];
	logic [RULE_W-1:0]  rule_q = RULE_RESET;
	logic [COUNT_W-1:0] rows_q = COUNT_RESET;
	logic [COUNT_W-1:0] cols_q = COUNT_RESET;

	rgb_t next_gen_q [$];
	rgb_t want;
	int   mismatch_count = 0;
	int   results_checked = 0;
	int   writes_sent = 0;
	int   evals_sent = 0;
	int   settings_used = 0;
	int   burst_left = 0;
	int   idle_cycles = 0;

	function automatic int grid_extent(logic [COUNT_W-1:0] v, int max_v);
		if (v == 0)
			return 1;
		return (v > max_v) ? max_v : int'(v);
	endfunction

	function automatic int word_addr(int r, int c);
		return r * DEF_MAX_COLS + c;
	endfunction

	function automatic logic [23:0] life_next_gen(int r, int c);
		int rows, cols, nr, nc, idx;
		int live [N_PLANES];
		logic [23:0] px, self_px, next;
		rows = grid_extent(rows_q, DEF_MAX_ROWS);
		cols = grid_extent(cols_q, DEF_MAX_COLS);
		next = '0;
		for (int k = 0; k < N_PLANES; k++)
			live[k] = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				if (dr == 0 && dc == 0)
					continue;
				nr = (r + rows + dr) % rows;
				nc = (c + cols + dc) % cols;
				px = pixel_copy[word_addr(nr, nc)];
				for (int k = 0; k < N_PLANES; k++)
					live[k] += px[k];
			end
		end
		self_px = pixel_copy[word_addr(r, c)];
		for (int k = 0; k < N_PLANES; k++) begin
			idx = live[k] + (self_px[k] ? int'(SURVIVE_OFFSET) : 0);
			next[k] = rule_q[idx];
		end
		return next;
	endfunction

	// pixel content with varied density so sparse and crowded neighbourhoods occur
	function automatic logic [23:0] rand_pixel();
		logic [23:0] a, b, c;
		a = 24'($urandom);
		b = 24'($urandom);
		c = 24'($urandom);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return a & b & c;
			4, 5: return a | b | c;
			default: return a;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_v);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch %s: got %02h expected %02h at %0t", what, got, exp_v, $realtime);
		mismatch_count++;
	endtask

	// one input transaction; entered and left at a falling edge
	task automatic send_item(logic op, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
			logic [23:0] px);
		int gap, r, c;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid  <= 1'b1;
		operation <= op;
		cell_row  <= row;
		cell_col  <= col;
		red_in    <= px[23:16];
		green_in  <= px[15:8];
		blue_in   <= px[7:0];
		do
			@(posedge clk);
		while (in_stall);
		r = int'(row) % grid_extent(rows_q, DEF_MAX_ROWS);
		c = int'(col) % grid_extent(cols_q, DEF_MAX_COLS);
		if (op == OP_WRITE) begin
			pixel_copy[word_addr(r, c)] = px;
			pixel_written[word_addr(r, c)] = 1'b1;
			writes_sent++;
		end else begin
			next_gen_q.push_back(rgb_t'(life_next_gen(r, c)));
			evals_sent++;
		end
		@(negedge clk);
		burst_left--;
	endtask

	// writes any unwritten pixel of the neighbourhood first, then evaluates
	task automatic eval_cell(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
		int rows, cols, r, c, nr, nc;
		rows = grid_extent(rows_q, DEF_MAX_ROWS);
		cols = grid_extent(cols_q, DEF_MAX_COLS);
		r = int'(row) % rows;
		c = int'(col) % cols;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				nr = (r + rows + dr) % rows;
				nc = (c + cols + dc) % cols;
				if (!pixel_written[word_addr(nr, nc)])
					send_item(OP_WRITE, COORD_W'(nr), COORD_W'(nc), rand_pixel());
			end
		end
		send_item(OP_EVAL, row, col, 24'($urandom));
	endtask

	// register write once the engine has drained
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [RULE_W-1:0] data);
		in_valid <= 1'b0;
		burst_left = 0;
		while (next_gen_q.size() != 0)
			@(negedge clk);
		repeat (CFG_HOLDOFF) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_RULE_WORD: rule_q = data;
			REG_ROW_COUNT: rows_q = data[COUNT_W-1:0];
			REG_COL_COUNT: cols_q = data[COUNT_W-1:0];
			default: ;
		endcase
		settings_used++;
	endtask

	// reset rule on the full grid, neighbourhoods wrapping over the top, bottom, left and right edges
	task automatic test_conway_wrap_corners();
		send_item(OP_WRITE, 6'd63, 6'd63, 24'hFFFFFF);
		send_item(OP_WRITE, 6'd63, 6'd0,  24'h000000);
		send_item(OP_WRITE, 6'd63, 6'd1,  24'hF0F0F0);
		send_item(OP_WRITE, 6'd0,  6'd63, 24'h0F0F0F);
		send_item(OP_WRITE, 6'd0,  6'd0,  24'hAAAAAA);
		send_item(OP_WRITE, 6'd0,  6'd1,  24'h555555);
		send_item(OP_WRITE, 6'd1,  6'd63, 24'hFF00FF);
		send_item(OP_WRITE, 6'd1,  6'd0,  24'h00FF00);
		send_item(OP_WRITE, 6'd1,  6'd1,  24'h123456);
		eval_cell(6'd0, 6'd0);
		eval_cell(6'd63, 6'd63);
	endtask

	// one by one grid: all eight neighbours are the cell itself
	task automatic test_single_cell_grid();
		set_reg(REG_RULE_WORD, 18'h20001);
		set_reg(REG_ROW_COUNT, 18'd1);
		set_reg(REG_COL_COUNT, 18'd1);
		send_item(OP_WRITE, 6'd45, 6'd22, 24'hFFFFFF);
		eval_cell(6'd63, 6'd0);
		send_item(OP_WRITE, 6'd3, 6'd63, 24'h000000);
		eval_cell(6'd0, 6'd63);
		send_item(OP_WRITE, 6'd0, 6'd0, 24'h0F3C81);
		eval_cell(6'd17, 6'd40);
	endtask

	// zero acts as one, oversize clamps to the maximum, junk above bit 6 ignored
	task automatic test_size_clamping();
		set_reg(REG_RULE_WORD, RULE_RESET);
		set_reg(REG_ROW_COUNT, {11'h7FF, 7'd0});
		set_reg(REG_COL_COUNT, {11'h7FF, 7'd127});
		eval_cell(6'd33, 6'd63);
		set_reg(REG_ROW_COUNT, 18'd2);
		set_reg(REG_COL_COUNT, 18'd2);
		eval_cell(6'd5, 6'd7);
	endtask

	task automatic test_unused_register();
		set_reg(REG_UNUSED, 18'($urandom));
		eval_cell(6'd1, 6'd0);
	endtask

	task automatic test_random_traffic(int phases, int per_phase);
		logic [COUNT_W-1:0] rows_v, cols_v;
		logic [RULE_W-1:0]  rule_v;
		int start;
		for (int p = 0; p < phases; p++) begin
			case (p)
				0: begin rows_v = 7'd1;   cols_v = 7'd1;   rule_v = 18'($urandom); end
				1: begin rows_v = 7'd64;  cols_v = 7'd2;   rule_v = '0;            end
				2: begin rows_v = 7'd127; cols_v = 7'd0;   rule_v = '1;            end
				3: begin rows_v = 7'd3;   cols_v = 7'd64;  rule_v = RULE_RESET;    end
				default: begin
					rows_v = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(1, 8))
							: 7'($urandom_range(0, 127));
					cols_v = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(1, 8))
							: 7'($urandom_range(0, 127));
					rule_v = 18'($urandom);
				end
			endcase
			set_reg(REG_RULE_WORD, rule_v);
			set_reg(REG_ROW_COUNT, {11'($urandom), rows_v});
			set_reg(REG_COL_COUNT, {11'($urandom), cols_v});
			start = writes_sent + evals_sent;
			while (writes_sent + evals_sent - start < per_phase) begin
				if ($urandom_range(0, 9) < 3)
					send_item(OP_WRITE, 6'($urandom), 6'($urandom), rand_pixel());
				else
					eval_cell(6'($urandom), 6'($urandom));
			end
		end
	endtask

	// receiver stall pattern: random choice among four stall modes, switched over the run
	int stall_mode = 0;
	int stall_cycle = 0;
	int stall_run = 0;
	always @(negedge clk) begin
		if (stall_cycle % 256 == 0)
			stall_mode = $urandom_range(0, 3);
		stall_cycle++;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_run == 0)
					stall_run = $urandom_range(1, 30);
				stall_run--;
				out_stall <= ((stall_cycle / 32) % 2 == 1) && (stall_run > 10);
			end
		endcase
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (next_gen_q.size() == 0) begin
				report_mismatch("unexpected result red", red_out, 8'h00);
			end else begin
				want = next_gen_q.pop_front();
				results_checked++;
				if (red_out !== want.red)
					report_mismatch("red_out", red_out, want.red);
				if (green_out !== want.green)
					report_mismatch("green_out", green_out, want.green);
				if (blue_out !== want.blue)
					report_mismatch("blue_out", blue_out, want.blue);
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("tb_bitplane_life_cell_engine NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_conway_wrap_corners();
		test_single_cell_grid();
		test_size_clamping();
		test_unused_register();
		test_random_traffic(8, 225);
		in_valid <= 1'b0;
		while (next_gen_q.size() != 0)
			@(negedge clk);
		repeat (END_HOLDOFF) @(posedge clk);
		if (next_gen_q.size() != 0)
			mismatch_count++;
		$display("ran %0d pixel writes and %0d evaluates over %0d register writes",
				writes_sent, evals_sent, settings_used);
		$display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("tb_bitplane_life_cell_engine OK");
		else
			$display("tb_bitplane_life_cell_engine NOT OK");
		$finish;
	end

endmodule
